[src/frir_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package frir_pkg;

    // Region table depth and derived widths
    localparam int MAX_REGIONS = 16;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int OUT_CNT_W   = 5;

    // Request codes
    localparam logic [2:0] REQ_SET_FOCUS     = 3'd0;
    localparam logic [2:0] REQ_CLEAR_FOCUS   = 3'd1;
    localparam logic [2:0] REQ_VIEW_DESTROY  = 3'd2;
    localparam logic [2:0] REQ_SET_MODE      = 3'd3;
    localparam logic [2:0] REQ_REGION_LOAD   = 3'd4;
    localparam logic [2:0] REQ_CLEAR_REGIONS = 3'd5;
    localparam logic [2:0] REQ_MOUSE_QUERY   = 3'd6;

    // Capture modes
    localparam logic MODE_FULL    = 1'b0;
    localparam logic MODE_REGIONS = 1'b1;

    typedef struct packed {
        logic        [2:0]  req_type;
        logic        [31:0] view_id;
        logic               capture_sel;
        logic               list_start;
        logic               entry_present;
        logic signed [31:0] rect_left;
        logic signed [31:0] rect_top;
        logic signed [31:0] rect_width;
        logic signed [31:0] rect_height;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } in_word_t;

    typedef struct packed {
        logic                 route_mouse;
        logic                 cursor_held;
        logic [OUT_CNT_W-1:0] stored_regions;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] width;
        logic signed [31:0] height;
    } rect_t;

endpackage

`default_nettype wire

[src/focused_region_input_router_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                      | Word       | Direction
// --------+------------------------------+------------+----------
// request | in_valid, in_ready, in_data  | in_word_t  | into core
// answer  | out_valid, out_ready, out_data | out_word_t | out of core
//
// One request at a time. A request is taken in IDLE, applied in the next
// cycle, and its answer word is loaded in EMIT once the output register
// is free. A mouse query in regions-only mode walks the stored rectangles
// through the region RAM read port and the one shared hit tester, one
// rectangle per cycle, stopping at the first hit or after the last one.
// rst_n clears focus, mode, cursor flag and count; the region RAM is not
// cleared, entries at or beyond the count are never read.
// A stalled answer holds in the output register; the next request may be
// taken meanwhile, and its answer waits in EMIT until the register frees.
module focused_region_input_router_core
    import frir_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t            state_reg,   state_next;
    in_word_t          req_reg,     req_next;
    logic [31:0]       focus_reg,   focus_next;
    logic              mode_reg,    mode_next;
    logic              cursor_reg,  cursor_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  idx_reg,     idx_next;
    logic              pend_reg,    pend_next;
    logic              route_reg,   route_next;
    logic              ovalid_reg,  ovalid_next;
    out_word_t         oword_reg,   oword_next;

    // Region RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    rect_t             ram_wdata;
    logic              ram_re;
    rect_t             ram_rdata;
    logic              hit;

    logic              in_fire;
    logic              out_free;
    logic [CNT_W-1:0]  load_base;
    logic              view_match;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !ovalid_reg || out_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = oword_reg;

    assign view_match = (focus_reg == req_reg.view_id);
    assign load_base  = req_reg.list_start ? '0 : count_reg;

    // Write a rectangle only for the focused, nonzero view and while room is left
    assign ram_we = (state_reg == ST_EXEC) && (req_reg.req_type == REQ_REGION_LOAD)
                 && (req_reg.view_id != 32'd0) && view_match
                 && req_reg.entry_present && (load_base < CNT_W'(MAX_REGIONS));
    assign ram_waddr = load_base[IDX_W-1:0];
    assign ram_wdata = '{left:   req_reg.rect_left,
                         top:    req_reg.rect_top,
                         width:  req_reg.rect_width,
                         height: req_reg.rect_height};

    // Issue one read per scan cycle until the count is reached
    assign ram_re = (state_reg == ST_SCAN) && (idx_reg < count_reg);

    frir_ram #(
        .WIDTH ($bits(rect_t)),
        .DEPTH (MAX_REGIONS)
    ) u_region_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    frir_hit u_hit (
        .point_x (req_reg.point_x),
        .point_y (req_reg.point_y),
        .rect    (ram_rdata),
        .hit     (hit)
    );

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        focus_next  = focus_reg;
        mode_next   = mode_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        route_next  = route_reg;
        ovalid_next = ovalid_reg;
        oword_next  = oword_reg;

        // Drop the answer once taken
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next   = in_data;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                route_next = 1'b0;
                state_next = ST_EMIT;
                case (req_reg.req_type)
                    REQ_SET_FOCUS:
                    begin
                        if (!view_match)
                        begin
                            count_next = '0;
                            mode_next  = MODE_FULL;
                        end
                        focus_next  = req_reg.view_id;
                        cursor_next = (req_reg.view_id != 32'd0);
                    end
                    REQ_CLEAR_FOCUS:
                    begin
                        if ((req_reg.view_id == 32'd0) || view_match)
                        begin
                            focus_next  = '0;
                            mode_next   = MODE_FULL;
                            cursor_next = 1'b0;
                            count_next  = '0;
                        end
                    end
                    REQ_VIEW_DESTROY:
                    begin
                        if ((req_reg.view_id != 32'd0) && view_match)
                        begin
                            focus_next  = '0;
                            mode_next   = MODE_FULL;
                            cursor_next = 1'b0;
                            count_next  = '0;
                        end
                    end
                    REQ_SET_MODE:
                    begin
                        mode_next = req_reg.capture_sel;
                    end
                    REQ_REGION_LOAD:
                    begin
                        if ((req_reg.view_id != 32'd0) && view_match)
                        begin
                            count_next = ram_we ? (load_base + 1'b1) : load_base;
                        end
                    end
                    REQ_CLEAR_REGIONS:
                    begin
                        count_next = '0;
                    end
                    REQ_MOUSE_QUERY:
                    begin
                        if (focus_reg == 32'd0)
                        begin
                            route_next = 1'b0;
                        end
                        else if (mode_reg == MODE_FULL)
                        begin
                            route_next = 1'b1;
                        end
                        else if (count_reg != '0)
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        // unused code: no change
                    end
                endcase
            end

            ST_SCAN:
            begin
                pend_next = ram_re;
                if (ram_re)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                // Stop at the first hit, or after the last read returns
                if (pend_reg && hit)
                begin
                    route_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (!ram_re && (pend_reg || (idx_reg >= count_reg)))
                begin
                    route_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = '{route_mouse:    route_reg,
                                    cursor_held:    cursor_reg,
                                    stored_regions: OUT_CNT_W'(count_reg)};
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            req_reg    <= '0;
            focus_reg  <= '0;
            mode_reg   <= MODE_FULL;
            cursor_reg <= 1'b0;
            count_reg  <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            route_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            oword_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            req_reg    <= req_next;
            focus_reg  <= focus_next;
            mode_reg   <= mode_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            route_reg  <= route_next;
            ovalid_reg <= ovalid_next;
            oword_reg  <= oword_next;
        end
    end

    // The table never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count exceeds table depth");

    // The cursor is owned exactly when a view holds focus
    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg == (focus_reg != 32'd0))
        else $error("cursor flag out of step with focus");

    // A scan runs only for a focused view in regions-only mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((focus_reg != 32'd0) && (mode_reg == MODE_REGIONS)))
        else $error("scan outside regions-only focus");

    // State changes only while a request is applied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EXEC) |=> ($stable(count_reg) && $stable(focus_reg)))
        else $error("state changed outside request apply");

endmodule

`default_nettype wire

[src/frir_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module frir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/frir_hit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Half-open containment test of one point against one rectangle
module frir_hit
    import frir_pkg::*;
(
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire rect_t              rect,
    output logic                    hit
);

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] wx;
    logic signed [32:0] hy;

    // Offsets from the corner, no overflow at 33 bits
    assign dx = $signed({point_x[31], point_x}) - $signed({rect.left[31], rect.left});
    assign dy = $signed({point_y[31], point_y}) - $signed({rect.top[31], rect.top});
    assign wx = $signed({rect.width[31], rect.width});
    assign hy = $signed({rect.height[31], rect.height});

    assign hit = (rect.width > 32'sd0) && (rect.height > 32'sd0)
              && !dx[32] && !dy[32] && (dx < wx) && (dy < hy);

endmodule

`default_nettype wire

[dv/focused_region_input_router_core_tb.sv]
`timescale 1ns / 1ps

// Request/answer testbench for the focused-region input router.
// A scoreboard object keeps its own copy of the router state, predicts the
// answer word of every request the core takes, and compares answers in order.
module focused_region_input_router_core_tb;
    import frir_pkg::*;

    // Request code with no meaning; the core must answer it without any change
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // Give up after this many clocks
    localparam int CYCLE_LIMIT   = 1000000;
    // Clocks to linger after the last answer, above the longest query scan
    localparam int DRAIN_CYCLES  = 40;

    // ------------------------------------------------------------------
    // Scoreboard: state copy, answer predictor and in-order answer check
    // ------------------------------------------------------------------
    class route_scoreboard;
        logic [31:0] focus_view;
        logic        capture_mode;
        logic        cursor_owned;
        int          region_count;
        rect_t       regions [MAX_REGIONS];
        out_word_t   pending_answers [$];
        int          mismatches;
        int          answers_seen;

        function new();
            clear_state();
            mismatches   = 0;
            answers_seen = 0;
        endfunction

        function void clear_state();
            focus_view   = '0;
            capture_mode = MODE_FULL;
            cursor_owned = 1'b0;
            region_count = 0;
        endfunction

        // Half-open containment, sums formed in 64 bits so they cannot wrap
        function bit point_hits(logic signed [31:0] px, logic signed [31:0] py);
            longint x;
            longint y;
            longint l;
            longint t;
            x = px;
            y = py;
            for (int i = 0; i < region_count; i++) begin
                if ($signed(regions[i].width) <= 0 || $signed(regions[i].height) <= 0)
                    continue;
                l = $signed(regions[i].left);
                t = $signed(regions[i].top);
                if (x >= l && y >= t &&
                    x < l + longint'($signed(regions[i].width)) &&
                    y < t + longint'($signed(regions[i].height)))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Apply one accepted request word and queue the answer it must produce
        function void note_request(in_word_t w);
            out_word_t answer;
            logic      route;
            route = 1'b0;
            case (w.req_type)
                REQ_SET_FOCUS: begin
                    if (focus_view != w.view_id) begin
                        region_count = 0;
                        capture_mode = MODE_FULL;
                    end
                    focus_view   = w.view_id;
                    cursor_owned = (w.view_id != '0);
                end
                REQ_CLEAR_FOCUS: begin
                    if (w.view_id == '0 || w.view_id == focus_view)
                        clear_state();
                end
                REQ_VIEW_DESTROY: begin
                    if (w.view_id != '0 && w.view_id == focus_view)
                        clear_state();
                end
                REQ_SET_MODE: capture_mode = w.capture_sel;
                REQ_REGION_LOAD: begin
                    if (w.view_id != '0 && w.view_id == focus_view) begin
                        if (w.list_start)
                            region_count = 0;
                        if (w.entry_present && region_count < MAX_REGIONS) begin
                            regions[region_count] = '{left: w.rect_left, top: w.rect_top,
                                                      width: w.rect_width,
                                                      height: w.rect_height};
                            region_count++;
                        end
                    end
                end
                REQ_CLEAR_REGIONS: region_count = 0;
                REQ_MOUSE_QUERY: begin
                    if (focus_view != '0)
                        route = (capture_mode == MODE_FULL) ||
                                point_hits(w.point_x, w.point_y);
                end
                default: ;
            endcase
            answer.route_mouse    = route;
            answer.cursor_held    = cursor_owned;
            answer.stored_regions = OUT_CNT_W'(region_count);
            pending_answers.push_back(answer);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("MISMATCH answer %0d %s: got %0h want %0h",
                     answers_seen, what, got, want);
            mismatches++;
        endtask

        // Compare one accepted answer word against the oldest prediction
        task check_answer(out_word_t got);
            out_word_t want;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected word", got, 0);
            end
            else begin
                want = pending_answers.pop_front();
                if (got.route_mouse !== want.route_mouse)
                    report_mismatch("route_mouse", got.route_mouse, want.route_mouse);
                if (got.cursor_held !== want.cursor_held)
                    report_mismatch("cursor_held", got.cursor_held, want.cursor_held);
                if (got.stored_regions !== want.stored_regions)
                    report_mismatch("stored_regions", got.stored_regions,
                                    want.stored_regions);
            end
            answers_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and core
    // ------------------------------------------------------------------
    logic      clk           = 1'b0;
    logic      rst_n         = 1'b0;
    logic      in_valid      = 1'b0;
    logic      in_ready;
    in_word_t  in_data       = '0;
    logic      out_valid;
    logic      out_ready     = 1'b0;
    out_word_t out_data;

    route_scoreboard board;
    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int          cycle_count       = 0;
    logic [31:0] view_pool [3];

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    focused_region_input_router_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Watch both channels at each edge; note requests before checking answers
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                board.note_request(in_data);
            if (out_valid && out_ready)
                board.check_answer(out_data);
        end
    end

    // Receiver: stall at random at the current idle rate, one decision per edge
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);

    // Hard stop for a hung core
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------

    // Fill every field with noise, then set the request code and view
    function automatic in_word_t make_word(logic [2:0] req, logic [31:0] view);
        logic [255:0] raw;
        in_word_t     w;
        raw = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(in_word_t)-1:0];
        w.req_type = req;
        w.view_id  = view;
        return w;
    endfunction

    function automatic in_word_t rect_word(logic [31:0] view, logic start,
                                           logic [31:0] l, logic [31:0] t,
                                           logic [31:0] wd, logic [31:0] ht);
        in_word_t w;
        w = make_word(REQ_REGION_LOAD, view);
        w.list_start    = start;
        w.entry_present = 1'b1;
        w.rect_left     = l;
        w.rect_top      = t;
        w.rect_width    = wd;
        w.rect_height   = ht;
        return w;
    endfunction

    function automatic in_word_t point_word(logic [31:0] x, logic [31:0] y);
        in_word_t w;
        w = make_word(REQ_MOUSE_QUERY, $urandom);
        w.point_x = x;
        w.point_y = y;
        return w;
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Land on an edge of a stored rectangle, just outside it, or inside it
    function automatic logic [31:0] edge_offset(logic signed [31:0] size);
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return size - 1;
            3:       return size;
            default: return (size > 0) ? $urandom_range(size - 1) : 32'd0;
        endcase
    endfunction

    // Mostly views that matter: the pool or the focused one; sometimes none
    function automatic logic [31:0] pick_view();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return view_pool[$urandom_range(2)];
            5, 6:          return board.focus_view;
            7:             return 32'h0;
            default:       return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks; each starts and ends at a rising edge
    // ------------------------------------------------------------------

    // Offer one request word and hold it until the core takes it.
    // Valid stays high after acceptance so words can go back to back.
    task automatic send_request(in_word_t w);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and hold off until every predicted answer has arrived
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_answers.size() != 0);
    endtask

    // Directed words: field extremes, every request and each corner case
    task automatic run_directed();
        in_word_t    w;
        logic [31:0] view_a;
        logic [31:0] view_b;
        view_a = 32'hFFFF_FFFF;
        view_b = 32'h0000_0001;
        // nothing focused: a query never routes
        send_request(point_word($urandom, $urandom));
        send_request(make_word(REQ_SET_FOCUS, view_a));
        // full capture routes anywhere
        send_request(point_word($urandom, $urandom));
        w = make_word(REQ_SET_MODE, $urandom);
        w.capture_sel = MODE_REGIONS;
        send_request(w);
        // regions only with an empty list
        send_request(point_word($urandom, $urandom));
        send_request(rect_word(view_a, 1'b1, 32'h8000_0000, 32'h8000_0000, 1, 1));
        send_request(point_word(32'h8000_0000, 32'h8000_0000));
        // right and bottom edges past the 32-bit range
        send_request(rect_word(view_a, 1'b0, 32'h7FFF_FFF0, 0, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF));
        send_request(point_word(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(point_word(32'h7FFF_FFEF, 5));
        // zero width and negative height are stored but never match
        send_request(rect_word(view_a, 1'b0, 100, 100, 0, 10));
        send_request(rect_word(view_a, 1'b0, 200, 200, 10, 32'hFFFF_FFFF));
        send_request(point_word(100, 100));
        send_request(point_word(200, 200));
        // continuation without a rectangle changes nothing
        w = rect_word(view_a, 1'b0, 0, 0, 10, 10);
        w.entry_present = 1'b0;
        send_request(w);
        // loads for another view or for no view are dropped
        send_request(rect_word(view_b, 1'b1, 0, 0, 10, 10));
        send_request(rect_word(32'h0, 1'b1, 0, 0, 10, 10));
        // refocusing the same view keeps list and mode
        send_request(make_word(REQ_SET_FOCUS, view_a));
        send_request(point_word(32'h8000_0000, 32'h8000_0000));
        // a list start with no rectangle empties the list
        w = rect_word(view_a, 1'b1, 0, 0, 10, 10);
        w.entry_present = 1'b0;
        send_request(w);
        // new view: list cleared, back to full capture
        send_request(make_word(REQ_SET_FOCUS, view_b));
        send_request(make_word(REQ_CLEAR_FOCUS, 32'h1234_5678));
        send_request(make_word(REQ_VIEW_DESTROY, 32'h0));
        send_request(make_word(REQ_VIEW_DESTROY, view_b));
        send_request(make_word(REQ_SET_FOCUS, view_a));
        send_request(make_word(REQ_CLEAR_FOCUS, 32'h0));
        send_request(make_word(REQ_SET_FOCUS, 32'h0));
        send_request(make_word(REQ_CLEAR_REGIONS, $urandom));
        send_request(make_word(REQ_UNUSED, $urandom));
    endtask

    // Random words, weighted toward focus, regions-only mode, region lists
    // and queries aimed at stored rectangles
    task automatic run_random(int count);
        in_word_t    w;
        rect_t       r;
        logic [31:0] view;
        int          done;
        int          len;
        int          pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick == 0) begin
                hold_until_drained();
            end
            if (pick < 8) begin
                send_request(make_word(REQ_SET_FOCUS, pick_view()));
                done++;
            end
            else if (pick < 12) begin
                send_request(make_word(REQ_CLEAR_FOCUS, pick_view()));
                done++;
            end
            else if (pick < 15) begin
                send_request(make_word(REQ_VIEW_DESTROY, pick_view()));
                done++;
            end
            else if (pick < 22) begin
                w = make_word(REQ_SET_MODE, $urandom);
                w.capture_sel = ($urandom_range(9) < 7) ? MODE_REGIONS : MODE_FULL;
                send_request(w);
                done++;
            end
            else if (pick < 50) begin
                // one region list, long enough at times to overflow the table
                len  = $urandom_range(1, 20);
                view = ($urandom_range(9) < 8) ? board.focus_view : pick_view();
                for (int k = 0; k < len; k++) begin
                    w = make_word(REQ_REGION_LOAD, view);
                    w.list_start    = (k == 0) ? ($urandom_range(9) != 0)
                                               : ($urandom_range(19) == 0);
                    w.entry_present = ($urandom_range(9) != 0);
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: begin
                            w.rect_left   = int'($urandom_range(200)) - 100;
                            w.rect_top    = int'($urandom_range(200)) - 100;
                            w.rect_width  = int'($urandom_range(60)) - 5;
                            w.rect_height = int'($urandom_range(60)) - 5;
                        end
                        6, 7: ;
                        default: begin
                            w.rect_left   = extreme_value();
                            w.rect_top    = extreme_value();
                            w.rect_width  = extreme_value();
                            w.rect_height = extreme_value();
                        end
                    endcase
                    send_request(w);
                    done++;
                end
            end
            else if (pick < 53) begin
                send_request(make_word(REQ_CLEAR_REGIONS, $urandom));
                done++;
            end
            else if (pick < 55) begin
                // unused code; does not count as work
                send_request(make_word(REQ_UNUSED, $urandom));
            end
            else begin
                w = make_word(REQ_MOUSE_QUERY, $urandom);
                if (board.region_count != 0 && $urandom_range(3) != 0) begin
                    r = board.regions[$urandom_range(board.region_count - 1)];
                    w.point_x = r.left + edge_offset(r.width);
                    w.point_y = r.top + edge_offset(r.height);
                end
                else if ($urandom_range(1) == 0) begin
                    w.point_x = int'($urandom_range(240)) - 120;
                    w.point_y = int'($urandom_range(240)) - 120;
                end
                send_request(w);
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin
        board = new();
        view_pool[0] = 32'h0000_0001;
        view_pool[1] = 32'h8000_0000;
        view_pool[2] = $urandom | 32'h1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // light sender gaps against a receiver that stalls most of the time
        sender_idle_pct   = 18;
        receiver_idle_pct = 87;
        run_directed();
        run_random(630);
        hold_until_drained();

        // sparse sender against a mostly ready receiver
        sender_idle_pct   = 87;
        receiver_idle_pct = 18;
        run_random(630);

        // full rate on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(640);

        // release the channel and wait out the tail
        in_valid <= 1'b0;
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
